// ----- src/evs_pkg.sv -----
// Shared types and codes for the stream eviction victim selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package evs_pkg;

    localparam logic [2:0] KIND_ORDER  = 3'd0;
    localparam logic [2:0] KIND_RECORD = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_FLUSH  = 3'd4;

    // Q8.8 all-ones importance: overrides forced marks
    localparam logic [15:0] IMP_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  position;
        logic [8:0]  list_length;
        logic [7:0]  image_index;
        logic        in_use;
        logic        forced;
        logic        loading;
        logic        streaming;
        logic        reduced_mips;
        logic [15:0] importance;
        logic [30:0] byte_count;
        logic [30:0] tracked_bytes;
    } evs_in_t;

    typedef struct packed {
        logic       granted;
        logic       fits_directly;
        logic       victim_valid;
        logic [7:0] victim_index;
    } evs_res_t;

    typedef struct packed {
        logic        in_use;
        logic        forced;
        logic        loading;
        logic        streaming;
        logic        reduced;
        logic [15:0] importance;
        logic [30:0] loaded_bytes;
    } evs_rec_t;

    typedef struct packed {
        logic     done;
        evs_res_t res;
    } evs_eval_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WB,
        ST_QUERY,
        ST_SCAN,
        ST_RESULT
    } evs_state_t;

endpackage

`default_nettype wire

// ----- src/evs_order_store.sv -----
// Importance-sorted order list memory and its valid length register.
// Depends on evs_pkg.
`default_nettype none

module evs_order_store import evs_pkg::*; #(
    parameter int ORDER_DEPTH = 256,
    localparam int OAW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1,
    localparam int OLW = $clog2(ORDER_DEPTH + 1)
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_en,
    input  wire logic [7:0]     wr_pos,
    input  wire logic [7:0]     wr_img,
    input  wire logic [8:0]     wr_len,
    input  wire logic           rd_en,
    input  wire logic [OAW-1:0] rd_addr,
    output logic [7:0]          rd_data,
    output logic [OLW-1:0]      order_len
);

    localparam int ORW = (OLW > 9) ? OLW : 9;

    logic [7:0]     mem [ORDER_DEPTH];
    logic [OLW-1:0] len_reg, len_next;
    logic [ORW-1:0] pos_ext, len_ext, len_sat;
    logic           pos_ok;

    always_comb begin
        pos_ext  = ORW'(wr_pos);
        len_ext  = ORW'(wr_len);
        pos_ok   = pos_ext < ORW'(ORDER_DEPTH);
        len_sat  = (len_ext > ORW'(ORDER_DEPTH)) ? ORW'(ORDER_DEPTH) : len_ext;
        len_next = wr_en ? len_sat[OLW-1:0] : len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && pos_ok) begin
            mem[pos_ext[OAW-1:0]] <= wr_img;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    assign order_len = len_reg;

endmodule

`default_nettype wire

// ----- src/evs_record_store.sv -----
// Per-image record memory: marks, importance and loaded size.
// Depends on evs_pkg.
`default_nettype none

module evs_record_store import evs_pkg::*; #(
    parameter int IMAGE_COUNT = 256,
    localparam int IAW = $clog2(IMAGE_COUNT)
) (
    input  wire logic           aclk,
    input  wire logic           wr_en,
    input  wire logic [IAW-1:0] wr_addr,
    input  wire evs_rec_t       wr_data,
    input  wire logic           rd_en,
    input  wire logic [IAW-1:0] rd_addr,
    output evs_rec_t            rd_data
);

    evs_rec_t mem [IMAGE_COUNT];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/evs_victim_eval.sv -----
// Victim test for one scanned record per cycle, with the fallback holder.
// Depends on evs_pkg.
`default_nettype none

module evs_victim_eval import evs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic        drained,
    input  wire logic        vld,
    input  wire logic [7:0]  img,
    input  wire evs_rec_t    rec,
    input  wire logic [15:0] thresh,
    input  wire logic [30:0] req_bytes,
    output evs_eval_t        ev
);

    logic       fb_vld_reg, fb_vld_next;
    logic [7:0] fb_img_reg, fb_img_next;
    logic       considered, stop, eligible, big;

    always_comb begin
        considered = rec.in_use && ((thresh == IMP_MAX) || !rec.forced);
        stop       = vld && considered && (rec.importance >= thresh);
        eligible   = vld && considered && (rec.importance < thresh) &&
                     !rec.loading && rec.streaming && !rec.reduced;
        big        = rec.loaded_bytes >= req_bytes;
    end

    // only the first eligible entry is kept as fallback
    always_comb begin
        fb_vld_next = fb_vld_reg;
        fb_img_next = fb_img_reg;
        if (start) begin
            fb_vld_next = 1'b0;
        end else if (eligible && !big && !fb_vld_reg) begin
            fb_vld_next = 1'b1;
            fb_img_next = img;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_vld_reg <= 1'b0;
        end else begin
            fb_vld_reg <= fb_vld_next;
        end
        fb_img_reg <= fb_img_next;
    end

    always_comb begin
        ev = '0;
        if (eligible && big) begin
            ev.done             = 1'b1;
            ev.res.granted      = 1'b1;
            ev.res.victim_valid = 1'b1;
            ev.res.victim_index = img;
        end else begin
            ev.done = stop || drained;
            if (fb_vld_reg) begin
                ev.res.granted      = 1'b1;
                ev.res.victim_valid = 1'b1;
                ev.res.victim_index = fb_img_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/stream_eviction_victim_selector.sv -----
// Stream eviction victim selector: top level with control sequencer and result register.
// Depends on evs_pkg, evs_order_store, evs_record_store, evs_victim_eval.
//
// Usage:
//   s_valid/s_ready/s_data carry one item (evs_in_t): order slot write, record
//   write, query, clear of one use mark, or flush of all use marks.
//   m_valid/m_ready/m_data return one evs_res_t per query and nothing else.
//   cfg_wr_en/cfg_wr_data set the buffer size; write only while idle.
// Sequencing:
//   Order and record writes complete when the item is taken; a use-mark clear
//   reads the record and writes it back. A query that fits passes ST_QUERY and
//   ST_RESULT to m_valid; otherwise the order list is read from its end one slot
//   per cycle, through the order memory and then the record memory, until a
//   victim is found, the scan stops or the list is drained. A flush walks the
//   record memory.
// Reset:
//   aresetn low clears the buffer size and list length; afterwards a clearing
//   pass over every record zeroes the use marks with s_ready low.
// Stall:
//   The result register frees the sequencer: new items are taken while a
//   result waits; a second query result holds until m_ready frees the slot.
`default_nettype none

module stream_eviction_victim_selector import evs_pkg::*; #(
    parameter int ORDER_DEPTH = 256,
    parameter int IMAGE_COUNT = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire evs_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output evs_res_t         m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [30:0] cfg_wr_data
);

    localparam int OAW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
    localparam int OLW = $clog2(ORDER_DEPTH + 1);
    localparam int IAW = $clog2(IMAGE_COUNT);
    localparam int ICW = $clog2(IMAGE_COUNT + 1);
    localparam int IRW = (ICW > 8) ? ICW : 8;

    evs_state_t state_reg, state_next;

    logic [30:0]    buf_size_reg;
    logic [ICW-1:0] sw_reg;
    logic           sw_issue;
    logic           acc;
    logic           in_img_ok, ord_img_ok;
    logic [IRW-1:0] in_img_ext, ord_img_ext;
    logic [31:0]    need;

    logic           q_fit_reg;
    logic [15:0]    q_imp_reg;
    logic [30:0]    q_bytes_reg;
    logic [OLW-1:0] n_reg, n_dec;

    logic           p1_vld_reg, p2_vld_reg;
    logic [7:0]     p2_img_reg;
    logic           wb_vld_reg;
    logic [IAW-1:0] wb_addr_reg;

    evs_res_t       res_reg;
    logic           m_valid_reg;
    evs_res_t       m_data_reg;
    logic           out_free;

    // memory ports
    logic           ord_we, ord_re;
    logic [7:0]     ord_rd_data;
    logic [OLW-1:0] order_len;
    logic           rec_we, rec_re;
    logic [IAW-1:0] rec_wa, rec_ra;
    evs_rec_t       rec_wd, rec_rd_data, in_rec, wb_rec;

    logic           scan_go, drained;
    evs_eval_t      ev;

    assign drained = (state_reg == ST_SCAN) && (n_reg == '0) && !p1_vld_reg && !p2_vld_reg;

    always_comb begin
        acc         = s_valid && s_ready;
        in_img_ext  = IRW'(s_data.image_index);
        in_img_ok   = in_img_ext < IRW'(IMAGE_COUNT);
        ord_img_ext = IRW'(ord_rd_data);
        ord_img_ok  = ord_img_ext < IRW'(IMAGE_COUNT);
        sw_issue    = (state_reg == ST_SWEEP) && (sw_reg < ICW'(IMAGE_COUNT));
        need        = {1'b0, s_data.byte_count} + {1'b0, s_data.tracked_bytes};
        n_dec       = n_reg - 1'b1;
        out_free    = !m_valid_reg || m_ready;
        scan_go     = (state_reg == ST_SCAN) && !ev.done;

        in_rec.in_use       = s_data.in_use;
        in_rec.forced       = s_data.forced;
        in_rec.loading      = s_data.loading;
        in_rec.streaming    = s_data.streaming;
        in_rec.reduced      = s_data.reduced_mips;
        in_rec.importance   = s_data.importance;
        in_rec.loaded_bytes = s_data.byte_count;

        wb_rec        = rec_rd_data;
        wb_rec.in_use = 1'b0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (sw_reg == ICW'(IMAGE_COUNT)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    unique case (s_data.kind)
                        KIND_CLEAR: if (in_img_ok) state_next = ST_WB;
                        KIND_FLUSH: state_next = ST_SWEEP;
                        KIND_QUERY: state_next = ST_QUERY;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WB:     state_next = ST_IDLE;
            ST_QUERY:  state_next = q_fit_reg ? ST_RESULT : ST_SCAN;
            ST_SCAN: begin
                if (ev.done) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and memory strobes
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        ord_we  = acc && (s_data.kind == KIND_ORDER);
        ord_re  = (state_reg == ST_SCAN) && (n_reg != '0) && !ev.done;

        rec_re = 1'b0;
        rec_ra = sw_reg[IAW-1:0];
        if (sw_issue) begin
            rec_re = 1'b1;
        end else if (acc && (s_data.kind == KIND_CLEAR) && in_img_ok) begin
            rec_re = 1'b1;
            rec_ra = in_img_ext[IAW-1:0];
        end else if (p1_vld_reg && ord_img_ok && scan_go) begin
            rec_re = 1'b1;
            rec_ra = ord_img_ext[IAW-1:0];
        end

        rec_we = 1'b0;
        rec_wa = wb_addr_reg;
        rec_wd = wb_rec;
        if (wb_vld_reg) begin
            rec_we = 1'b1;
        end else if (acc && (s_data.kind == KIND_RECORD) && in_img_ok) begin
            rec_we = 1'b1;
            rec_wa = in_img_ext[IAW-1:0];
            rec_wd = in_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            sw_reg       <= '0;
            buf_size_reg <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            wb_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) buf_size_reg <= cfg_wr_data;
            if (acc && (s_data.kind == KIND_FLUSH)) begin
                sw_reg <= '0;
            end else if (sw_issue) begin
                sw_reg <= sw_reg + 1'b1;
            end
            p1_vld_reg <= ord_re;
            p2_vld_reg <= scan_go && p1_vld_reg && ord_img_ok;
            wb_vld_reg <= sw_issue || (acc && (s_data.kind == KIND_CLEAR) && in_img_ok);
            if (state_reg == ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (acc && (s_data.kind == KIND_QUERY)) begin
            q_fit_reg   <= need <= {1'b0, buf_size_reg};
            q_imp_reg   <= s_data.importance;
            q_bytes_reg <= s_data.byte_count;
        end
        if (state_reg == ST_QUERY) begin
            n_reg <= order_len;
        end else if (ord_re) begin
            n_reg <= n_dec;
        end
        p2_img_reg  <= ord_rd_data;
        wb_addr_reg <= rec_ra;
        if (state_reg == ST_QUERY) begin
            res_reg <= '{granted: 1'b1, fits_directly: 1'b1, victim_valid: 1'b0,
                         victim_index: 8'd0};
        end else if (state_reg == ST_SCAN && ev.done) begin
            res_reg <= ev.res;
        end
        if (state_reg == ST_RESULT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    evs_order_store #(
        .ORDER_DEPTH(ORDER_DEPTH)
    ) u_order (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (ord_we),
        .wr_pos    (s_data.position),
        .wr_img    (s_data.image_index),
        .wr_len    (s_data.list_length),
        .rd_en     (ord_re),
        .rd_addr   (n_dec[OAW-1:0]),
        .rd_data   (ord_rd_data),
        .order_len (order_len)
    );

    evs_record_store #(
        .IMAGE_COUNT(IMAGE_COUNT)
    ) u_record (
        .aclk    (aclk),
        .wr_en   (rec_we),
        .wr_addr (rec_wa),
        .wr_data (rec_wd),
        .rd_en   (rec_re),
        .rd_addr (rec_ra),
        .rd_data (rec_rd_data)
    );

    evs_victim_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == ST_QUERY),
        .drained   (drained),
        .vld       (p2_vld_reg),
        .img       (p2_img_reg),
        .rec       (rec_rd_data),
        .thresh    (q_imp_reg),
        .req_bytes (q_bytes_reg),
        .ev        (ev)
    );

    // write-back of a cleared use mark never meets an accepted item
    a_wb_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_vld_reg |-> (state_reg == ST_WB || state_reg == ST_SWEEP))
        else $error("use-mark write-back outside clear or sweep");

    // scan pipeline is flushed whenever the scan ends
    a_scan_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_vld_reg |-> state_reg == ST_SCAN)
        else $error("scan stage valid outside scan");

    a_victim_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.victim_valid) |-> (m_data.granted && !m_data.fits_directly))
        else $error("victim result without grant");

    a_no_victim_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.victim_valid) |-> (m_data.victim_index == 8'd0))
        else $error("victim index set without victim");

endmodule

`default_nettype wire

// ----- tb/tb_stream_eviction_victim_selector.sv -----
// Self-checking testbench for stream_eviction_victim_selector: directed and random items,
// a shadow copy of the image records and order list predicts every query verdict.
// Depends on evs_pkg and the stream_eviction_victim_selector RTL.
`timescale 1ns / 1ps

module tb_stream_eviction_victim_selector;
    import evs_pkg::*;

    localparam int ORDER_SLOTS    = 256;
    localparam int IMAGE_SLOTS    = 256;
    localparam int IDLE_PCT       = 21;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 60;
    localparam logic [30:0] BYTES_MAX = 31'h7FFF_FFFF;

    typedef struct {
        bit          in_use;
        bit          forced;
        bit          loading;
        bit          streaming;
        bit          reduced;
        logic [15:0] importance;
        logic [30:0] loaded;
    } image_rec_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    evs_in_t     s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    evs_res_t    m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [30:0] cfg_wr_data = '0;

    // shadow of the block
    logic [7:0]  order_slots [ORDER_SLOTS];
    int          order_len    = 0;
    image_rec_t  image_tab [IMAGE_SLOTS];
    logic [30:0] buffer_bytes = '0;
    evs_res_t    pending_verdicts[$];

    // stimulus bookkeeping: only written slots and records may be scanned
    bit          rec_written  [IMAGE_SLOTS];
    bit          slot_written [ORDER_SLOTS];
    int          slot_prefix  = 0;

    int          fail_count    = 0;
    bit          idle_on       = 1'b1;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    stream_eviction_victim_selector u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic evs_res_t pick_victim(input evs_in_t item);
        evs_res_t    verdict;
        logic [31:0] need;
        bit          have_alt;
        logic [7:0]  alt;
        logic [7:0]  img;
        verdict  = '0;
        have_alt = 1'b0;
        alt      = '0;
        need     = 32'(item.byte_count) + 32'(item.tracked_bytes);
        if (need <= 32'(buffer_bytes)) begin
            verdict.granted       = 1'b1;
            verdict.fits_directly = 1'b1;
            return verdict;
        end
        for (int n = order_len - 1; n >= 0; n--) begin
            img = order_slots[n];
            if (!image_tab[img].in_use) continue;
            if (item.importance != IMP_MAX && image_tab[img].forced) continue;
            if (image_tab[img].importance >= item.importance) break;
            if (image_tab[img].loading || !image_tab[img].streaming || image_tab[img].reduced)
                continue;
            if (image_tab[img].loaded >= item.byte_count) begin
                verdict.granted      = 1'b1;
                verdict.victim_valid = 1'b1;
                verdict.victim_index = img;
                return verdict;
            end
            if (!have_alt) begin
                have_alt = 1'b1;
                alt      = img;
            end
        end
        if (have_alt) begin
            verdict.granted      = 1'b1;
            verdict.victim_valid = 1'b1;
            verdict.victim_index = alt;
        end
        return verdict;
    endfunction

    function automatic void apply_to_shadow(input evs_in_t item);
        case (item.kind)
            KIND_ORDER: begin
                order_slots[item.position] = item.image_index;
                order_len = (item.list_length > ORDER_SLOTS) ? ORDER_SLOTS
                                                             : int'(item.list_length);
            end
            KIND_RECORD: begin
                image_tab[item.image_index] = '{item.in_use, item.forced, item.loading,
                                                item.streaming, item.reduced_mips,
                                                item.importance, item.byte_count};
            end
            KIND_QUERY: pending_verdicts.push_back(pick_victim(item));
            KIND_CLEAR: image_tab[item.image_index].in_use = 1'b0;
            KIND_FLUSH: foreach (image_tab[i]) image_tab[i].in_use = 1'b0;
            default: ;
        endcase
    endfunction

    // ---------------- item builders ----------------

    function automatic evs_in_t rand_item();
        logic [127:0] raw;
        evs_in_t      item;
        raw  = {$urandom(), $urandom(), $urandom(), $urandom()};
        item = raw[$bits(evs_in_t)-1:0];
        return item;
    endfunction

    function automatic logic [30:0] pick_size();
        if ($urandom_range(99) < 80) return 31'($urandom_range(0, 4000));
        return 31'($urandom());
    endfunction

    function automatic logic [15:0] pick_importance();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 25) return IMP_MAX;
        return 16'($urandom());
    endfunction

    function automatic void mark_slot(input int pos);
        slot_written[pos] = 1'b1;
        while (slot_prefix < ORDER_SLOTS && slot_written[slot_prefix]) slot_prefix++;
    endfunction

    function automatic logic [8:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 9'($urandom_range(0, (slot_prefix < 48) ? slot_prefix : 48));
        if (r < 85 || slot_prefix < ORDER_SLOTS) return 9'($urandom_range(0, slot_prefix));
        return 9'($urandom_range(ORDER_SLOTS, 2 * ORDER_SLOTS - 1));
    endfunction

    function automatic evs_in_t record_item(input logic [7:0] idx);
        evs_in_t item;
        item              = rand_item();
        item.kind         = KIND_RECORD;
        item.image_index  = idx;
        item.in_use       = $urandom_range(99) < 85;
        item.forced       = $urandom_range(99) < 20;
        item.loading      = $urandom_range(99) < 15;
        item.streaming    = $urandom_range(99) < 85;
        item.reduced_mips = $urandom_range(99) < 15;
        item.importance   = pick_importance();
        item.byte_count   = pick_size();
        rec_written[idx]  = 1'b1;
        return item;
    endfunction

    // order entries only ever name images whose record has been written
    function automatic evs_in_t slot_item(input logic [7:0] pos);
        evs_in_t    item;
        logic [7:0] img;
        do img = 8'($urandom_range(IMAGE_SLOTS - 1)); while (!rec_written[img]);
        item             = rand_item();
        item.kind        = KIND_ORDER;
        item.position    = pos;
        item.image_index = img;
        mark_slot(pos);
        item.list_length = pick_length();
        return item;
    endfunction

    function automatic logic [7:0] pick_position();
        if (slot_prefix < ORDER_SLOTS) return 8'($urandom_range(0, slot_prefix));
        return 8'($urandom_range(ORDER_SLOTS - 1));
    endfunction

    function automatic evs_in_t query_item();
        evs_in_t     item;
        int unsigned r;
        item            = rand_item();
        item.kind       = KIND_QUERY;
        item.importance = pick_importance();
        item.byte_count = pick_size();
        r = $urandom_range(99);
        if (r < 20)
            item.tracked_bytes = (buffer_bytes > item.byte_count)
                ? 31'($urandom_range(0, buffer_bytes - item.byte_count)) : '0;
        else if (r < 60)
            item.tracked_bytes = 31'($urandom());
        else    // right at the fit boundary
            item.tracked_bytes = buffer_bytes - item.byte_count + 31'($urandom_range(0, 1));
        return item;
    endfunction

    function automatic evs_in_t clear_item();
        evs_in_t item;
        item      = rand_item();
        item.kind = KIND_CLEAR;
        if (order_len > 0 && $urandom_range(99) < 70)
            item.image_index = order_slots[$urandom_range(order_len - 1)];
        return item;
    endfunction

    function automatic logic [30:0] pick_buffer();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return '0;
        if (r < 40) return BYTES_MAX;
        if (r < 70) return 31'($urandom_range(0, 20000));
        return 31'($urandom());
    endfunction

    // ---------------- driving ----------------

    task automatic send_item(input evs_in_t item);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_to_shadow(item);
    endtask

    // flushes and clears give no result, so let the block settle after the last verdict
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_buffer_size(input logic [30:0] bytes);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        buffer_bytes  = bytes;
    endtask

    task automatic put_record(input logic [7:0] idx, input logic [4:0] marks,
                              input logic [15:0] imp, input logic [30:0] bytes);
        evs_in_t item;
        item = record_item(idx);
        {item.in_use, item.forced, item.loading, item.streaming, item.reduced_mips} = marks;
        item.importance = imp;
        item.byte_count = bytes;
        send_item(item);
    endtask

    task automatic put_slot(input logic [7:0] pos, input logic [7:0] img);
        evs_in_t item;
        item             = rand_item();
        item.kind        = KIND_ORDER;
        item.position    = pos;
        item.image_index = img;
        item.list_length = 9'(pos) + 9'd1;
        mark_slot(pos);
        send_item(item);
    endtask

    task automatic put_query(input logic [15:0] imp, input logic [30:0] bytes,
                             input logic [30:0] tracked);
        evs_in_t item;
        item               = rand_item();
        item.kind          = KIND_QUERY;
        item.importance    = imp;
        item.byte_count    = bytes;
        item.tracked_bytes = tracked;
        send_item(item);
    endtask

    task automatic put_plain(input logic [2:0] kind);
        evs_in_t item;
        item      = rand_item();
        item.kind = kind;
        send_item(item);
    endtask

    // ---------------- tests ----------------

    task automatic test_fit_check();
        set_buffer_size('0);
        put_query(16'h8000, '0, '0);
        put_query(16'h8000, 31'd1, '0);     // empty list: nothing to evict
        wait_idle();
        set_buffer_size(BYTES_MAX);
        put_query(IMP_MAX, BYTES_MAX, BYTES_MAX);   // sum needs the 32nd bit
        put_query(IMP_MAX, BYTES_MAX, '0);
    endtask

    task automatic test_scan_rules();
        wait_idle();
        set_buffer_size(31'd100);
        // marks: use, forced, loading, streaming, reduced
        put_record(8'd0,   5'b10010, 16'h0100, 31'd50);
        put_record(8'd255, 5'b10010, 16'h0200, 31'd200);
        put_record(8'd7,   5'b11010, 16'h0050, 31'd1000);
        put_record(8'd9,   5'b10110, 16'h0000, 31'd1000);
        put_record(8'd10,  5'b10000, 16'h0010, 31'd1000);
        put_record(8'd11,  5'b10011, 16'h0010, 31'd1000);
        put_slot(8'd0, 8'd255);
        put_slot(8'd1, 8'd0);
        put_slot(8'd2, 8'd11);
        put_slot(8'd3, 8'd10);
        put_slot(8'd4, 8'd9);
        put_slot(8'd5, 8'd7);
        put_query(16'h1000, 31'd80, 31'd100);   // big enough entry wins over earlier small one
        put_query(16'h0180, 31'd80, 31'd100);   // scan stops at 255, small entry taken
        put_query(IMP_MAX,  31'd80, 31'd100);   // max importance overrides the forced mark
        put_query(16'h0000, 31'd80, 31'd100);   // forced 7 skipped, importance-zero entry 9 stops the scan: no victim
        put_plain(KIND_CLEAR);
        put_slot(8'd0, 8'd255);                 // same slot, list length drops to one
        put_plain(KIND_FLUSH);
        put_query(16'h1000, 31'd80, 31'd100);
        put_plain(KIND_FLUSH + 3'd1);
        put_plain(KIND_FLUSH + 3'd2);
        put_plain(KIND_FLUSH + 3'd3);
        put_query(IMP_MAX, 31'd80, 31'd100);
    endtask

    task automatic test_use_clear();
        evs_in_t item;
        put_record(8'd0,   5'b10010, 16'h0100, 31'd50);
        put_record(8'd255, 5'b10010, 16'h0200, 31'd200);
        put_slot(8'd5, 8'd7);
        item             = rand_item();
        item.kind        = KIND_CLEAR;
        item.image_index = 8'd255;
        send_item(item);
        put_query(16'h1000, 31'd80, 31'd100);   // 255 no longer in use: falls back to 0
    endtask

    task automatic test_long_list();
        evs_in_t item;
        wait_idle();
        set_buffer_size(31'd5000);
        for (int k = 0; k < 40; k++) send_item(record_item(8'($urandom_range(255))));
        for (int k = 0; k < ORDER_SLOTS; k++) begin
            item             = slot_item(8'(k));
            item.list_length = 9'(k + 1);
            send_item(item);
        end
        repeat (3) send_item(query_item());
        item             = slot_item(8'($urandom_range(255)));
        item.list_length = 9'h1FF;              // saturates to the full depth
        send_item(item);
        repeat (3) send_item(query_item());
    endtask

    task automatic test_backpressure();
        hold_requests++;
        repeat (12) send_item(query_item());
        wait_idle();
    endtask

    task automatic test_random(input int target);
        int          sent;
        int          burst;
        int unsigned pick;
        sent = 0;
        while (sent < target) begin
            idle_on = (sent < 15 || sent >= 45);
            pick    = $urandom_range(99);
            burst   = $urandom_range(1, 5);
            if (pick < 6) begin
                wait_idle();
                set_buffer_size(pick_buffer());
            end else if (pick < 30) begin
                repeat (burst) send_item(record_item(8'($urandom_range(255))));
                sent += burst;
            end else if (pick < 45) begin
                repeat (burst) send_item(slot_item(pick_position()));
                sent += burst;
            end else if (pick < 85) begin
                repeat (burst) send_item(query_item());
                sent += burst;
            end else if (pick < 92) begin
                send_item(clear_item());
                sent++;
            end else if (pick < 95) begin
                put_plain(KIND_FLUSH);
                sent++;
            end else if (pick < 98) begin
                put_plain(KIND_FLUSH + 3'($urandom_range(1, 3)));
            end else begin
                wait_idle();
            end
        end
        idle_on = 1'b1;
    endtask

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_ready     <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        evs_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                fail_count++;
                $display("%0t: result with no query pending: expected none got %p",
                         $time, m_data);
            end else begin
                want = pending_verdicts.pop_front();
                check_field("granted",       want.granted,       m_data.granted);
                check_field("fits_directly", want.fits_directly, m_data.fits_directly);
                check_field("victim_valid",  want.victim_valid,  m_data.victim_valid);
                check_field("victim_index",  want.victim_index,  m_data.victim_index);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_fit_check();
        test_scan_rules();
        test_use_clear();
        test_long_list();
        test_backpressure();
        test_random(RANDOM_ITEMS);
        wait_idle();
        if (pending_verdicts.size() != 0) fail_count++;
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
src/evs_pkg.sv
src/evs_order_store.sv
src/evs_record_store.sv
src/evs_victim_eval.sv
src/stream_eviction_victim_selector.sv
tb/tb_stream_eviction_victim_selector.sv
